// ===== src/che_pkg.sv =====
// ----------------------------------------------------------------------------
// che_pkg: shared types and constants for the chunk header encoder
// Transaction structs, job descriptor, sequencer segments and register map.
// ----------------------------------------------------------------------------
`default_nettype none

package che_pkg;

  // chunk stream id limits and basic header encoding
  localparam logic [16:0] CS_MIN           = 17'd2;
  localparam logic [16:0] CS_MAX           = 17'd65599;
  localparam logic [16:0] CS_ONE_BYTE_MAX  = 17'd63;
  localparam logic [16:0] CS_TWO_BYTE_LIM  = 17'd320;
  localparam logic [16:0] CS_OFFSET        = 17'd64;

  // timestamp escape and continuation marker
  localparam logic [23:0] TS_ESCAPE = 24'hffffff;
  localparam logic [7:0]  CONT_MARK = 8'hc0;

  // register reset values
  localparam logic [16:0] STREAM_LIMIT_RESET    = 17'd32;
  localparam logic        REPEAT_EXT_TIME_RESET = 1'b0;

  // header formats
  localparam logic [1:0] FMT_FULL      = 2'd0;
  localparam logic [1:0] FMT_NO_STREAM = 2'd1;
  localparam logic [1:0] FMT_TIME_ONLY = 2'd2;
  localparam logic [1:0] FMT_NONE      = 2'd3;

  // job queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

  // configuration register map
  localparam int CFG_INDEX_W = 2;
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_STREAM_LIMIT    = 2'd0,
    REG_REPEAT_EXT_TIME = 2'd1
  } cfg_reg_t;

  // input transaction
  typedef struct packed {
    logic [16:0] chunk_stream;
    logic [31:0] message_stream;
    logic [7:0]  message_type;
    logic [31:0] time_stamp;
    logic [23:0] message_length;
    logic        have_previous;
    logic [31:0] prev_stream;
    logic [7:0]  prev_type;
    logic [23:0] prev_length;
    logic [31:0] prev_time;
  } in_t;

  // output transaction
  typedef struct packed {
    logic [7:0] header_byte;
    logic       byte_part;
    logic [1:0] chosen_format;
    logic       bad_stream;
    logic       run_end;
  } out_t;

  // classified message, one queue entry
  typedef struct packed {
    logic        bad;
    logic [1:0]  fmt;
    logic [1:0]  nbasic;
    logic [7:0]  basic0;
    logic [7:0]  basic1;
    logic [7:0]  basic2;
    logic [23:0] delta;
    logic        ext;
    logic        rep_ext;
    logic [31:0] ext_ts;
    logic [23:0] mlen;
    logic [7:0]  mtype;
    logic [31:0] msid;
  } job_t;

  // byte sequencer segments
  typedef enum logic [3:0] {
    SEG_IDLE,
    SEG_ERR,
    SEG_BASIC,
    SEG_DELTA,
    SEG_MLEN,
    SEG_MSID,
    SEG_EXT,
    SEG_CBASIC,
    SEG_CEXT
  } seg_t;

endpackage

`default_nettype wire

// ===== src/che_front.sv =====
// ----------------------------------------------------------------------------
// che_front: message classifier
// Picks the header format, timestamp delta, extended timestamp and basic
// header bytes for one message and packs them into a job descriptor.
// ----------------------------------------------------------------------------
`default_nettype none

module che_front (
  input  wire che_pkg::in_t  item,
  input  wire logic [16:0]   stream_limit,
  input  wire logic          repeat_ext_time,
  output che_pkg::job_t      job
);

  logic        same_stream;
  logic [1:0]  fmt;
  logic [31:0] delta;
  logic        ext;
  logic [16:0] cs_off;

  // format choice against the previous header
  always_comb begin
    same_stream = item.have_previous && (item.message_stream == item.prev_stream);
    fmt = che_pkg::FMT_FULL;
    if (same_stream) begin
      fmt = che_pkg::FMT_NO_STREAM;
      if ((item.message_type == item.prev_type) && (item.message_length != 24'd0)
          && (item.message_length == item.prev_length)) begin
        fmt = che_pkg::FMT_TIME_ONLY;
        if (item.time_stamp == item.prev_time) begin
          fmt = che_pkg::FMT_NONE;
        end
      end
    end
  end

  // timestamp delta and escape detection
  assign delta  = same_stream ? (item.time_stamp - item.prev_time) : item.time_stamp;
  assign ext    = (delta[31:24] != 8'd0) || (delta[23:0] == che_pkg::TS_ESCAPE);
  assign cs_off = item.chunk_stream - che_pkg::CS_OFFSET;

  // job descriptor
  always_comb begin
    job.bad = (item.chunk_stream < che_pkg::CS_MIN) ||
              (item.chunk_stream >= stream_limit) ||
              (item.chunk_stream > che_pkg::CS_MAX);
    job.fmt     = fmt;
    job.basic1  = cs_off[7:0];
    job.basic2  = cs_off[15:8];
    if (item.chunk_stream <= che_pkg::CS_ONE_BYTE_MAX) begin
      job.basic0 = {fmt, item.chunk_stream[5:0]};
      job.nbasic = 2'd1;
    end else if (item.chunk_stream < che_pkg::CS_TWO_BYTE_LIM) begin
      job.basic0 = {fmt, 6'd0};
      job.nbasic = 2'd2;
    end else begin
      job.basic0 = {fmt, 6'd1};
      job.nbasic = 2'd3;
    end
    job.delta   = ext ? che_pkg::TS_ESCAPE : delta[23:0];
    job.ext     = ext;
    job.rep_ext = ext && repeat_ext_time;
    job.ext_ts  = delta;
    job.mlen    = item.message_length;
    job.mtype   = item.message_type;
    job.msid    = item.message_stream;
  end

endmodule

`default_nettype wire

// ===== src/che_queue.sv =====
// ----------------------------------------------------------------------------
// che_queue: job queue
// Short first-in first-out store of classified jobs between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module che_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire che_pkg::job_t push_job,
  input  wire logic          pop,
  output logic               full,
  output logic               nonempty,
  output che_pkg::job_t      head
);

  che_pkg::job_t                  entries [che_pkg::QUEUE_DEPTH];
  logic [che_pkg::QUEUE_PTR_W-1:0] wr_ptr;
  logic [che_pkg::QUEUE_PTR_W-1:0] rd_ptr;
  logic [che_pkg::QUEUE_PTR_W:0]   count;

  assign full     = (count == (che_pkg::QUEUE_PTR_W + 1)'(che_pkg::QUEUE_DEPTH));
  assign nonempty = (count != '0);
  assign head     = entries[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // fill count stays within depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (che_pkg::QUEUE_PTR_W + 1)'(che_pkg::QUEUE_DEPTH))
    else $error("queue count exceeds depth");

  // no overflow or underflow
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full && !pop) && !(pop && !nonempty))
    else $error("queue overflow or underflow");

endmodule

`default_nettype wire

// ===== src/che_back.sv =====
// ----------------------------------------------------------------------------
// che_back: header byte sequencer
// Walks the segments of one job and emits one header byte per cycle, when not
// stalled by out_stall, through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module che_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          job_valid,
  input  wire che_pkg::job_t job_in,
  output logic               job_pop,
  output logic               out_valid,
  input  wire logic          out_stall,
  output che_pkg::out_t      out_item
);

  che_pkg::seg_t seg;
  che_pkg::seg_t seg_next;
  logic [1:0]    cnt;
  logic [1:0]    cnt_next;
  che_pkg::job_t job;
  logic [1:0]    seg_last_idx;
  logic          seg_end;
  che_pkg::seg_t after;
  logic          last;
  logic          advance;
  che_pkg::out_t cur;

  // segment following the given one for this job
  function automatic che_pkg::seg_t next_after(input che_pkg::seg_t s,
                                               input che_pkg::job_t j);
    che_pkg::seg_t body_end;
    body_end = j.ext ? che_pkg::SEG_EXT : che_pkg::SEG_CBASIC;
    unique case (s)
      che_pkg::SEG_BASIC:
        next_after = (j.fmt != che_pkg::FMT_NONE) ? che_pkg::SEG_DELTA : body_end;
      che_pkg::SEG_DELTA:
        next_after = ((j.fmt == che_pkg::FMT_FULL) || (j.fmt == che_pkg::FMT_NO_STREAM))
                     ? che_pkg::SEG_MLEN : body_end;
      che_pkg::SEG_MLEN:
        next_after = (j.fmt == che_pkg::FMT_FULL) ? che_pkg::SEG_MSID : body_end;
      che_pkg::SEG_MSID:   next_after = body_end;
      che_pkg::SEG_EXT:    next_after = che_pkg::SEG_CBASIC;
      che_pkg::SEG_CBASIC: next_after = j.rep_ext ? che_pkg::SEG_CEXT : che_pkg::SEG_IDLE;
      default:             next_after = che_pkg::SEG_IDLE;
    endcase
  endfunction

  // segment length and position
  always_comb begin
    unique case (seg)
      che_pkg::SEG_BASIC, che_pkg::SEG_CBASIC: seg_last_idx = job.nbasic - 2'd1;
      che_pkg::SEG_DELTA:                      seg_last_idx = 2'd2;
      che_pkg::SEG_MLEN, che_pkg::SEG_MSID,
      che_pkg::SEG_EXT, che_pkg::SEG_CEXT:     seg_last_idx = 2'd3;
      default:                                 seg_last_idx = 2'd0;
    endcase
  end

  assign seg_end = (cnt == seg_last_idx);
  assign after   = next_after(seg, job);
  assign last    = (seg != che_pkg::SEG_IDLE) && seg_end && (after == che_pkg::SEG_IDLE);
  assign advance = !out_valid || !out_stall;
  assign job_pop = advance && ((seg == che_pkg::SEG_IDLE) || last) && job_valid;

  // byte selection for the current step
  always_comb begin
    cur.byte_part     = (seg == che_pkg::SEG_CBASIC) || (seg == che_pkg::SEG_CEXT);
    cur.chosen_format = (seg == che_pkg::SEG_ERR) ? che_pkg::FMT_FULL : job.fmt;
    cur.bad_stream    = (seg == che_pkg::SEG_ERR);
    cur.run_end       = last;
    unique case (seg)
      che_pkg::SEG_BASIC, che_pkg::SEG_CBASIC: begin
        unique case (cnt)
          2'd0:    cur.header_byte = (seg == che_pkg::SEG_CBASIC)
                                     ? (job.basic0 | che_pkg::CONT_MARK) : job.basic0;
          2'd1:    cur.header_byte = job.basic1;
          default: cur.header_byte = job.basic2;
        endcase
      end
      che_pkg::SEG_DELTA: begin
        unique case (cnt)
          2'd0:    cur.header_byte = job.delta[23:16];
          2'd1:    cur.header_byte = job.delta[15:8];
          default: cur.header_byte = job.delta[7:0];
        endcase
      end
      che_pkg::SEG_MLEN: begin
        unique case (cnt)
          2'd0:    cur.header_byte = job.mlen[23:16];
          2'd1:    cur.header_byte = job.mlen[15:8];
          2'd2:    cur.header_byte = job.mlen[7:0];
          default: cur.header_byte = job.mtype;
        endcase
      end
      che_pkg::SEG_MSID: begin
        unique case (cnt)
          2'd0:    cur.header_byte = job.msid[7:0];
          2'd1:    cur.header_byte = job.msid[15:8];
          2'd2:    cur.header_byte = job.msid[23:16];
          default: cur.header_byte = job.msid[31:24];
        endcase
      end
      che_pkg::SEG_EXT, che_pkg::SEG_CEXT: begin
        unique case (cnt)
          2'd0:    cur.header_byte = job.ext_ts[31:24];
          2'd1:    cur.header_byte = job.ext_ts[23:16];
          2'd2:    cur.header_byte = job.ext_ts[15:8];
          default: cur.header_byte = job.ext_ts[7:0];
        endcase
      end
      default: cur.header_byte = 8'd0;
    endcase
  end

  // next segment and step
  always_comb begin
    seg_next = seg;
    cnt_next = cnt;
    if (advance) begin
      if ((seg == che_pkg::SEG_IDLE) || last) begin
        cnt_next = 2'd0;
        if (job_pop) begin
          seg_next = job_in.bad ? che_pkg::SEG_ERR : che_pkg::SEG_BASIC;
        end else begin
          seg_next = che_pkg::SEG_IDLE;
        end
      end else if (seg_end) begin
        seg_next = after;
        cnt_next = 2'd0;
      end else begin
        cnt_next = cnt + 2'd1;
      end
    end
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      seg <= che_pkg::SEG_IDLE;
      cnt <= 2'd0;
    end else begin
      seg <= seg_next;
      cnt <= cnt_next;
    end
  end

  // current job
  always_ff @(posedge clk) begin
    if (job_pop) begin
      job <= job_in;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= (seg != che_pkg::SEG_IDLE);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= cur;
    end
  end

  // an error transaction stands alone with zero payload
  a_err_alone: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.bad_stream |->
      out_item.run_end && (out_item.header_byte == 8'd0) && !out_item.byte_part)
    else $error("error transaction malformed");

  // continuation bytes are never followed by main bytes within one message
  a_part_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && out_item.byte_part && !out_item.run_end |=>
      !out_valid || out_item.byte_part)
    else $error("main header byte after continuation byte");

endmodule

`default_nettype wire

// ===== src/chunk_header_encoder.sv =====
// ----------------------------------------------------------------------------
// chunk_header_encoder: compressed chunk header encoder
// Classifies each message against its previous header, queues the result and
// streams main header and continuation template, one byte per unstalled cycle.
// ----------------------------------------------------------------------------
//  channel  direction  handshake               payload
//  in       receive    in_valid / in_stall     in_item   (che_pkg::in_t)
//  out      send       out_valid / out_stall   out_item  (che_pkg::out_t)
//  cfg      receive    cfg_valid / cfg_ready   cfg_index, cfg_data
//
//  one output transaction per cycle while not stalled; a message yields 2 to 25
//  bytes from the byte sequencer (one for a rejected stream id), set by its
//  header length; the first byte passes the queue, job and output registers
//  a four-entry job queue lets input be taken while the sequencer is busy
//  reset clears the queue and sequencer, stream_limit to 32, repeat flag to 0
//  in_stall rises only when the queue is full; cfg_ready is always high
// ----------------------------------------------------------------------------
`default_nettype none

module chunk_header_encoder (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire che_pkg::in_t                  in_item,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output che_pkg::out_t                      out_item,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [che_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [16:0]                   cfg_data
);

  logic          [16:0] stream_limit;
  logic                 repeat_ext_time;
  che_pkg::job_t        front_job;
  che_pkg::job_t        head_job;
  logic                 q_full;
  logic                 q_nonempty;
  logic                 q_pop;
  logic                 q_push;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      stream_limit    <= che_pkg::STREAM_LIMIT_RESET;
      repeat_ext_time <= che_pkg::REPEAT_EXT_TIME_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        che_pkg::REG_STREAM_LIMIT:    stream_limit    <= cfg_data;
        che_pkg::REG_REPEAT_EXT_TIME: repeat_ext_time <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // front: classify and enqueue
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  che_front u_front (
    .item            (in_item),
    .stream_limit    (stream_limit),
    .repeat_ext_time (repeat_ext_time),
    .job             (front_job)
  );

  che_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (front_job),
    .pop      (q_pop),
    .full     (q_full),
    .nonempty (q_nonempty),
    .head     (head_job)
  );

  // back: byte sequencer
  che_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (q_nonempty),
    .job_in    (head_job),
    .job_pop   (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

// ===== verif/che_checker.sv =====
// ----------------------------------------------------------------------------
// che_checker: scoreboard for the chunk header encoder
// Watches the config, input and output channels, rebuilds the header bytes
// of every accepted message and compares each output transaction in order.
// ----------------------------------------------------------------------------
`default_nettype none

module che_checker (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  input  wire logic                            in_stall,
  input  wire che_pkg::in_t                    in_item,
  input  wire logic                            out_valid,
  input  wire logic                            out_stall,
  input  wire che_pkg::out_t                   out_item,
  input  wire logic                            cfg_valid,
  input  wire logic                            cfg_ready,
  input  wire logic [che_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [16:0]                     cfg_data,
  output int                                   error_count,
  output int                                   outstanding
);

  // shadow copy of the register file
  logic [16:0] id_limit;
  logic        ext_in_template;

  // header bytes still owed by the block, oldest first
  che_pkg::out_t due_bytes[$];
  // bytes of the message being encoded
  che_pkg::out_t run_bytes[$];
  int            fails = 0;

  function automatic void add_byte(logic [7:0] value, logic part, logic [1:0] fmt);
    che_pkg::out_t b;
    b = '0;
    b.header_byte   = value;
    b.byte_part     = part;
    b.chosen_format = fmt;
    run_bytes.push_back(b);
  endfunction

  // extended timestamp, big-endian
  function automatic void add_ext_time(logic [31:0] stamp, logic part, logic [1:0] fmt);
    for (int k = 3; k >= 0; k--) add_byte(stamp[8*k +: 8], part, fmt);
  endfunction

  function automatic void encode_header(che_pkg::in_t m);
    logic [16:0]      cs;
    logic [16:0]      off;
    logic [1:0]       fmt;
    logic [31:0]      delta;
    logic [31:0]      ext_stamp;
    logic             ext;
    logic [2:0][7:0]  basic;
    int               nbasic;
    che_pkg::out_t    b;
    cs = m.chunk_stream;

    // rejected chunk stream id: one error transaction
    if (cs < che_pkg::CS_MIN || cs >= id_limit || cs > che_pkg::CS_MAX) begin
      b = '0;
      b.bad_stream = 1'b1;
      b.run_end    = 1'b1;
      due_bytes.push_back(b);
      return;
    end

    // format choice against the previous header
    fmt   = che_pkg::FMT_FULL;
    delta = m.time_stamp;
    if (m.have_previous && m.message_stream == m.prev_stream) begin
      fmt = che_pkg::FMT_NO_STREAM;
      if (m.message_type == m.prev_type && m.message_length != 0 &&
          m.message_length == m.prev_length) begin
        fmt = che_pkg::FMT_TIME_ONLY;
        if (m.time_stamp == m.prev_time) fmt = che_pkg::FMT_NONE;
      end
      delta = m.time_stamp - m.prev_time;
    end

    // escape to extended timestamp
    ext       = (delta >= {8'd0, che_pkg::TS_ESCAPE});
    ext_stamp = delta;
    if (ext) delta = {8'd0, che_pkg::TS_ESCAPE};

    // basic header, 1 to 3 bytes
    off   = cs - che_pkg::CS_OFFSET;
    basic = '0;
    if (cs <= che_pkg::CS_ONE_BYTE_MAX) begin
      basic[0] = {fmt, cs[5:0]};
      nbasic   = 1;
    end else if (cs < che_pkg::CS_TWO_BYTE_LIM) begin
      basic[0] = {fmt, 6'd0};
      basic[1] = off[7:0];
      nbasic   = 2;
    end else begin
      basic[0] = {fmt, 6'd1};
      basic[1] = off[7:0];
      basic[2] = off[15:8];
      nbasic   = 3;
    end

    // main header
    run_bytes.delete();
    for (int i = 0; i < nbasic; i++) add_byte(basic[i], 1'b0, fmt);
    if (fmt != che_pkg::FMT_NONE) begin
      add_byte(delta[23:16], 1'b0, fmt);
      add_byte(delta[15:8], 1'b0, fmt);
      add_byte(delta[7:0], 1'b0, fmt);
    end
    if (fmt == che_pkg::FMT_FULL || fmt == che_pkg::FMT_NO_STREAM) begin
      add_byte(m.message_length[23:16], 1'b0, fmt);
      add_byte(m.message_length[15:8], 1'b0, fmt);
      add_byte(m.message_length[7:0], 1'b0, fmt);
      add_byte(m.message_type, 1'b0, fmt);
    end
    // message stream id goes out little-endian
    if (fmt == che_pkg::FMT_FULL) begin
      for (int k = 0; k < 4; k++) add_byte(m.message_stream[8*k +: 8], 1'b0, fmt);
    end
    if (ext) add_ext_time(ext_stamp, 1'b0, fmt);

    // continuation template
    add_byte(basic[0] | che_pkg::CONT_MARK, 1'b1, fmt);
    for (int i = 1; i < nbasic; i++) add_byte(basic[i], 1'b1, fmt);
    if (ext && ext_in_template) add_ext_time(ext_stamp, 1'b1, fmt);

    foreach (run_bytes[i]) begin
      b = run_bytes[i];
      b.run_end = (i == run_bytes.size() - 1);
      due_bytes.push_back(b);
    end
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fails++;
    end
  endfunction

  // one pass per clock: config writes, output compare, input prediction
  always @(posedge clk) begin : monitor
    che_pkg::out_t want;
    if (rst) begin
      id_limit        = che_pkg::STREAM_LIMIT_RESET;
      ext_in_template = che_pkg::REPEAT_EXT_TIME_RESET;
      due_bytes.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == che_pkg::REG_STREAM_LIMIT) id_limit = cfg_data;
        else if (cfg_index == che_pkg::REG_REPEAT_EXT_TIME) ext_in_template = cfg_data[0];
      end
      if (out_valid && !out_stall) begin
        if (due_bytes.size() == 0) begin
          $display("%0t: unexpected output transaction, expected none, actual %h",
                   $time, out_item);
          fails++;
        end else begin
          want = due_bytes.pop_front();
          check_field("header_byte", want.header_byte, out_item.header_byte);
          check_field("byte_part", want.byte_part, out_item.byte_part);
          check_field("chosen_format", want.chosen_format, out_item.chosen_format);
          check_field("bad_stream", want.bad_stream, out_item.bad_stream);
          check_field("run_end", want.run_end, out_item.run_end);
        end
      end
      if (in_valid && !in_stall) encode_header(in_item);
    end
    error_count <= fails;
    outstanding <= due_bytes.size();
  end

endmodule

`default_nettype wire

// ===== verif/tb_chunk_header_encoder.sv =====
// ----------------------------------------------------------------------------
// tb_chunk_header_encoder: testbench top for the chunk header encoder
// Drives directed and random message headers through several register
// settings with random idling on both sides; the checker scores the bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_chunk_header_encoder;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD      = 80;
  localparam int SETTLE_CYCLES  = 30;
  localparam int PHASE_ITEMS    = 110;
  // index past the register map, writes to it are dropped
  localparam logic [che_pkg::CFG_INDEX_W-1:0] REG_UNMAPPED = 2'd3;

  logic                            clk       = 1'b0;
  logic                            rst       = 1'b1;
  logic                            in_valid  = 1'b0;
  logic                            in_stall;
  che_pkg::in_t                    in_item   = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  che_pkg::out_t                   out_item;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [che_pkg::CFG_INDEX_W-1:0] cfg_index = che_pkg::REG_STREAM_LIMIT;
  logic [16:0]                     cfg_data  = '0;

  int error_count;
  int outstanding;
  int idle_cycles = 0;
  bit hold_req    = 1'b0;
  bit no_idle     = 1'b0;

  chunk_header_encoder DUT (
    .clk, .rst,
    .in_valid, .in_stall, .in_item,
    .out_valid, .out_stall, .out_item,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  che_checker u_checker (
    .clk, .rst,
    .in_valid, .in_stall, .in_item,
    .out_valid, .out_stall, .out_item,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .error_count, .outstanding
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // give up when no channel has moved a transaction for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // receiver: random stall bursts, one long hold-off on request
  initial begin : receiver
    bit hold_taken;
    hold_taken = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic che_pkg::in_t message(logic [16:0] cs, logic [31:0] msid,
                                           logic [7:0] mtype, logic [31:0] ts,
                                           logic [23:0] mlen, logic havep,
                                           logic [31:0] pstream, logic [7:0] ptype,
                                           logic [23:0] plen, logic [31:0] ptime);
    che_pkg::in_t m;
    m.chunk_stream   = cs;
    m.message_stream = msid;
    m.message_type   = mtype;
    m.time_stamp     = ts;
    m.message_length = mlen;
    m.have_previous  = havep;
    m.prev_stream    = pstream;
    m.prev_type      = ptype;
    m.prev_length    = plen;
    m.prev_time      = ptime;
    return m;
  endfunction

  // mostly headers that match their previous one, so every format shows up
  function automatic che_pkg::in_t random_message();
    che_pkg::in_t m;
    m.message_stream = $urandom;
    m.message_type   = 8'($urandom);
    m.message_length = ($urandom_range(0, 3) == 0) ? 24'($urandom_range(0, 3))
                                                   : 24'($urandom);
    m.prev_time      = $urandom;
    m.have_previous  = ($urandom_range(0, 4) != 0);
    m.prev_stream    = ($urandom_range(0, 3) != 0) ? m.message_stream : $urandom;
    m.prev_type      = ($urandom_range(0, 2) != 0) ? m.message_type : 8'($urandom);
    m.prev_length    = ($urandom_range(0, 2) != 0) ? m.message_length : 24'($urandom);
    case ($urandom_range(0, 9))
      0, 1, 2: m.time_stamp = m.prev_time + $urandom_range(1, 5000);
      3, 4:    m.time_stamp = m.prev_time;
      5:       m.time_stamp = m.prev_time + 32'h00fffffe + $urandom_range(0, 2);
      6:       m.time_stamp = m.prev_time - $urandom_range(1, 5000);
      7:       m.time_stamp = $urandom_range(32'h00fffffe, 32'h01000000);
      default: m.time_stamp = $urandom;
    endcase
    case ($urandom_range(0, 9))
      0:       m.chunk_stream = 17'($urandom_range(0, 1));
      1:       m.chunk_stream = 17'($urandom_range(0, 131071));
      2, 3, 4: m.chunk_stream = 17'($urandom_range(2, 63));
      5, 6:    m.chunk_stream = 17'($urandom_range(64, 319));
      default: m.chunk_stream = 17'($urandom_range(320, 65599));
    endcase
    return m;
  endfunction

  // offer one input transaction, after an optional gap
  task automatic send_message(input che_pkg::in_t m);
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_item  <= m;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // stop offering and wait for every owed byte
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [che_pkg::CFG_INDEX_W-1:0] index,
                           input logic [16:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin : stimulus
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset values: limit 32, no extended time in template
    send_message(message(17'd0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_message(message(17'd1, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_message(message(17'd2, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_message(message(17'd31, '1, '1, 32'hfffffffe, '1, 0, '1, '1, '1, '1));
    send_message(message(17'd32, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    wait_drained();

    write_reg(che_pkg::REG_STREAM_LIMIT, 17'd65600);
    write_reg(che_pkg::REG_REPEAT_EXT_TIME, 17'd1);
    write_reg(REG_UNMAPPED, 17'h1ffff);

    // basic header sizes and the timestamp escape boundary
    send_message(message(17'd63, 32'h12345678, 8'h14, 32'h00fffffe, 24'h000100,
                         0, 0, 0, 0, 0));
    send_message(message(17'd64, 32'h1, 8'h09, 32'h00ffffff, 24'h00abcd, 0, 0, 0, 0, 0));
    send_message(message(17'd319, 32'h80000000, 8'h08, 32'h5a5a5a5a, 24'h800000,
                         0, 0, 0, 0, 0));
    send_message(message(17'd320, 32'h0, 8'h12, 32'h00000001, 24'h000001, 0, 0, 0, 0, 0));
    send_message(message(17'd65599, '1, '1, '1, '1, 0, '1, '1, '1, '1));
    send_message(message(17'd65600, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_message(message(17'h1ffff, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    // compressed formats against a previous header
    send_message(message(17'd5, 32'h7, 8'h09, 32'd1040, 24'd300, 1, 32'h7, 8'h08,
                         24'd300, 32'd1000));
    send_message(message(17'd6, 32'h7, 8'h09, 32'd1040, 24'd300, 1, 32'h7, 8'h09,
                         24'd300, 32'd1000));
    send_message(message(17'd7, 32'h7, 8'h09, 32'd1000, 24'd300, 1, 32'h7, 8'h09,
                         24'd300, 32'd1000));
    // zero length keeps format 1 even when everything matches
    send_message(message(17'd8, 32'h7, 8'h09, 32'd1000, 24'd0, 1, 32'h7, 8'h09,
                         24'd0, 32'd1000));
    // delta wraps below zero and needs the extended timestamp
    send_message(message(17'd400, 32'h9, 8'h09, 32'd10, 24'd5, 1, 32'h9, 8'h09,
                         24'd5, 32'd20));
    // equal streams but no previous header
    send_message(message(17'd9, 32'h7, 8'h09, 32'd1000, 24'd300, 0, 32'h7, 8'h09,
                         24'd300, 32'd1000));
    send_message(message(17'd100, 32'h3, 8'h01, 32'h01000010, 24'd7, 1, 32'h3, 8'h02,
                         24'd7, 32'h00000011));
    send_message(message(17'd101, 32'h3, 8'h01, 32'h01000010, 24'd7, 1, 32'h3, 8'h02,
                         24'd7, 32'h00000012));
    wait_drained();

    // lowest limit rejects every id
    write_reg(che_pkg::REG_STREAM_LIMIT, 17'd2);
    send_message(message(17'd2, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_message(message(17'd1, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_message(message(17'd65599, '1, '1, '1, '1, 1, '1, '1, '1, '1));
    wait_drained();

    // random phase with a long receiver hold-off
    write_reg(che_pkg::REG_STREAM_LIMIT, 17'd65600);
    write_reg(che_pkg::REG_REPEAT_EXT_TIME, 17'd0);
    hold_req <= 1'b1;
    repeat (PHASE_ITEMS) send_message(random_message());
    wait_drained();

    write_reg(che_pkg::REG_STREAM_LIMIT, 17'd300);
    write_reg(che_pkg::REG_REPEAT_EXT_TIME, 17'd1);
    repeat (PHASE_ITEMS) send_message(random_message());
    wait_drained();

    write_reg(che_pkg::REG_STREAM_LIMIT, 17'($urandom_range(64, 65600)));
    write_reg(che_pkg::REG_REPEAT_EXT_TIME, 17'($urandom_range(0, 1)));
    repeat (PHASE_ITEMS) send_message(random_message());
    wait_drained();

    // closing stretch with no random idling on either side
    write_reg(che_pkg::REG_STREAM_LIMIT, 17'd65600);
    write_reg(che_pkg::REG_REPEAT_EXT_TIME, 17'd1);
    no_idle <= 1'b1;
    repeat (PHASE_ITEMS) send_message(random_message());
    wait_drained();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

`default_nettype wire
